// ===== src/pba_pkg.sv =====
`timescale 1ns / 1ps

package pba_pkg;

    // defaults for the top level parameters
    localparam int POOL_PAGES_DEF      = 1024;
    localparam int PAGE_BYTES_LOG2_DEF = 7;

    // map word geometry
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    // field widths
    localparam int REQ_BYTES_W = 18;
    localparam int COUNT_W     = 11;
    localparam int PADDR_W     = 4;

    localparam logic [COUNT_W-1:0] POOL_PAGES_RST = 11'd1024;
    localparam int                 MIN_PAGES      = 2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_POOL_BASE      = 2'd0;
    localparam logic [1:0] REG_POOL_PAGES     = 2'd1;
    localparam logic [1:0] REG_RESERVED_PAGES = 2'd2;

    // request codes
    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    // result codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;

    typedef struct packed {
        logic [31:0]        pool_base;
        logic [COUNT_W-1:0] pool_pages;
        logic [COUNT_W-1:0] reserved_pages;
    } cfg_t;

endpackage

// ===== src/pba_cfg_regs.sv =====
`timescale 1ns / 1ps

module pba_cfg_regs
    import pba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_base      <= '0;
            cfg_reg.pool_pages     <= POOL_PAGES_RST;
            cfg_reg.reserved_pages <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_POOL_BASE:      cfg_reg.pool_base      <= pwdata;
                REG_POOL_PAGES:     cfg_reg.pool_pages     <= pwdata[COUNT_W-1:0];
                REG_RESERVED_PAGES: cfg_reg.reserved_pages <= pwdata[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POOL_BASE:      prdata = cfg_reg.pool_base;
            REG_POOL_PAGES:     prdata = 32'(cfg_reg.pool_pages);
            REG_RESERVED_PAGES: prdata = 32'(cfg_reg.reserved_pages);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== src/page_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps

// channel   ports                                              handshake
// -------   -------------------------------------------------  -------------------------------
// request   action, request_bytes, free_address                start & !busy at a rising edge
// result    status, block_address, pages_freed                 done high for one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata       write when psel&penable&pwrite
//
// scanning: one page bit per cycle through a single word buffer while no word change is due;
//   a word change first passes S_LOAD, which writes back the held word and fetches the next,
//   and in alloc each used page met passes S_CHECK before the scan goes on
// reset: a clearing pass writes every map word to zero, one word a cycle, with busy high;
//   configuration writes are taken throughout
// stalls: the receiver cannot stall; each result item shows for exactly one cycle on done

module page_bitmap_allocator_top
    import pba_pkg::*;
#(
    parameter int POOL_PAGES      = POOL_PAGES_DEF,
    parameter int PAGE_BYTES_LOG2 = PAGE_BYTES_LOG2_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // request item
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             action,
    input  logic [REQ_BYTES_W-1:0] request_bytes,
    input  logic [31:0]            free_address,
    // result item
    output logic                   done,
    output logic [1:0]             status,
    output logic [31:0]            block_address,
    output logic [COUNT_W-1:0]     pages_freed
);

    // map geometry
    localparam int WORDS  = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CUR_W  = $clog2(POOL_PAGES + 1);
    localparam int WANT_W = REQ_BYTES_W + 1 - PAGE_BYTES_LOG2;
    localparam int NEED_W = WANT_W + 1;

    localparam logic [REQ_BYTES_W:0] PAGE_MASK =
        (REQ_BYTES_W + 1)'((1 << PAGE_BYTES_LOG2) - 1);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_FREE_START,
        S_FREE,
        S_LOAD,
        S_FINISH
    } state_t;

    cfg_t cfg;

    pba_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer state
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [CUR_W-1:0]    cur_reg, cur_next;       // page under the cursor
    logic [CUR_W-1:0]    pos_reg, pos_next;       // start of the candidate run
    logic [CUR_W-1:0]    lim_reg, lim_next;       // live pool size
    logic [CUR_W-1:0]    rsv_reg, rsv_next;       // saturated reserved count
    logic [NEED_W-1:0]   run_reg, run_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [WANT_W-1:0]   want_reg, want_next;
    logic [WANT_W-1:0]   left_reg, left_next;
    logic [WIDX_W-1:0]   sweep_reg, sweep_next;
    logic [WIDX_W-1:0]   bidx_reg, bidx_next;     // word held in the buffer
    logic                bvalid_reg, bvalid_next;
    logic                dirty_reg, dirty_next;
    logic [31:0]         addr_reg, addr_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [31:0]         block_reg, block_next;
    logic [COUNT_W-1:0]  freed_reg, freed_next;

    // map memory and its word buffer
    logic [WORD_BITS-1:0] map_mem [WORDS];
    logic [WORD_BITS-1:0] buf_reg, buf_next;
    logic                 mem_we, mem_re;
    logic [WIDX_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // helpers
    logic [WIDX_W-1:0]     cur_widx;
    logic [WORD_SHIFT-1:0] bit_sel;
    logic                  need_word;
    logic [CUR_W-1:0]      lim_c;
    logic [REQ_BYTES_W:0]  bytes_sum;
    logic [WANT_W-1:0]     want_c;
    logic [31:0]           page32;
    logic [31:0]           rsv_hi;
    logic [WORD_SHIFT-1:0] rsv_lo;
    logic [WORD_BITS-1:0]  init_word;

    assign cur_widx  = WIDX_W'(cur_reg >> WORD_SHIFT);
    assign bit_sel   = WORD_SHIFT'(cur_reg);
    assign need_word = !bvalid_reg || (bidx_reg != cur_widx);

    assign lim_c = (32'(cfg.pool_pages) < 32'(POOL_PAGES)) ?
                   CUR_W'(cfg.pool_pages) : CUR_W'(POOL_PAGES);

    assign bytes_sum = (REQ_BYTES_W + 1)'(request_bytes) + PAGE_MASK;
    assign want_c    = WANT_W'(bytes_sum >> PAGE_BYTES_LOG2);

    assign page32 = (addr_reg - cfg.pool_base) >> PAGE_BYTES_LOG2;

    // init pattern: whole words below the reserved boundary, a partial word at it
    assign rsv_hi = 32'(rsv_reg >> WORD_SHIFT);
    assign rsv_lo = WORD_SHIFT'(rsv_reg);

    always_comb
    begin
        if (32'(sweep_reg) < rsv_hi)
        begin
            init_word = '1;
        end
        else if (32'(sweep_reg) == rsv_hi)
        begin
            init_word = (WORD_BITS'(1) << rsv_lo) - WORD_BITS'(1);
        end
        else
        begin
            init_word = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        lim_next    = lim_reg;
        rsv_next    = rsv_reg;
        run_next    = run_reg;
        need_next   = need_reg;
        want_next   = want_reg;
        left_next   = left_reg;
        sweep_next  = sweep_reg;
        bidx_next   = bidx_reg;
        bvalid_next = bvalid_reg;
        dirty_next  = dirty_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        block_next  = block_reg;
        freed_next  = freed_reg;
        buf_next    = buf_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = bidx_reg;
        mem_raddr   = cur_widx;
        mem_wdata   = buf_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + WIDX_W'(1);
                if (sweep_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    lim_next    = lim_c;
                    status_next = ST_OK;
                    block_next  = '0;
                    freed_next  = '0;
                    case (action)
                        ACT_INIT:
                        begin
                            sweep_next = '0;
                            rsv_next   = (32'(cfg.reserved_pages) < 32'(lim_c)) ?
                                         CUR_W'(cfg.reserved_pages) : lim_c;
                            state_next = S_INIT;
                        end
                        ACT_ALLOC:
                        begin
                            if (request_bytes == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                // single pages are rounded up to the minimum
                                if (want_c == WANT_W'(1))
                                begin
                                    want_next = WANT_W'(MIN_PAGES);
                                    need_next = NEED_W'(MIN_PAGES + 1);
                                end
                                else
                                begin
                                    want_next = want_c;
                                    need_next = NEED_W'(want_c) + NEED_W'(1);
                                end
                                pos_next   = '0;
                                cur_next   = '0;
                                run_next   = '0;
                                state_next = S_CHECK;
                            end
                        end
                        ACT_FREE:
                        begin
                            addr_next  = free_address;
                            state_next = S_FREE_START;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = init_word;
                sweep_next = sweep_reg + WIDX_W'(1);
                if (sweep_reg == LAST_WORD)
                begin
                    state_next = S_FINISH;
                end
            end

            // does the run starting at pos still fit in the pool
            S_CHECK:
            begin
                if ((32'(pos_reg) + 32'(need_reg)) > 32'(lim_reg))
                begin
                    status_next = ST_NO_FIT;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (need_word)
                begin
                    ret_next   = S_SCAN;
                    state_next = S_LOAD;
                end
                else if (!buf_reg[bit_sel])
                begin
                    if ((run_reg + NEED_W'(1)) == need_reg)
                    begin
                        // run found, skip the guard page and mark from there
                        block_next = cfg.pool_base +
                                     ((32'(pos_reg) + 32'd1) << PAGE_BYTES_LOG2);
                        cur_next   = pos_reg + CUR_W'(1);
                        left_next  = want_reg - WANT_W'(1);
                        state_next = S_MARK;
                    end
                    else
                    begin
                        run_next = run_reg + NEED_W'(1);
                        cur_next = cur_reg + CUR_W'(1);
                    end
                end
                else
                begin
                    // used page, restart just past it
                    pos_next   = cur_reg + CUR_W'(1);
                    cur_next   = cur_reg + CUR_W'(1);
                    run_next   = '0;
                    state_next = S_CHECK;
                end
            end

            S_MARK:
            begin
                if (need_word)
                begin
                    ret_next   = S_MARK;
                    state_next = S_LOAD;
                end
                else
                begin
                    buf_next[bit_sel] = 1'b1;
                    dirty_next        = 1'b1;
                    cur_next          = cur_reg + CUR_W'(1);
                    left_next         = left_reg - WANT_W'(1);
                    if (left_reg == WANT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FREE_START:
            begin
                if (page32 >= 32'(lim_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cur_next   = CUR_W'(page32);
                    state_next = S_FREE;
                end
            end

            S_FREE:
            begin
                if (cur_reg >= lim_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (need_word)
                begin
                    ret_next   = S_FREE;
                    state_next = S_LOAD;
                end
                else if (buf_reg[bit_sel])
                begin
                    buf_next[bit_sel] = 1'b0;
                    dirty_next        = 1'b1;
                    freed_next        = freed_reg + COUNT_W'(1);
                    cur_next          = cur_reg + CUR_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // write back the held word if changed, fetch the cursor's word
            S_LOAD:
            begin
                mem_we      = dirty_reg;
                mem_re      = 1'b1;
                bidx_next   = cur_widx;
                bvalid_next = 1'b1;
                dirty_next  = 1'b0;
                state_next  = ret_reg;
            end

            S_FINISH:
            begin
                mem_we      = dirty_reg;
                bvalid_next = 1'b0;
                dirty_next  = 1'b0;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ret_reg    <= S_SCAN;
            cur_reg    <= '0;
            pos_reg    <= '0;
            lim_reg    <= '0;
            rsv_reg    <= '0;
            run_reg    <= '0;
            need_reg   <= '0;
            want_reg   <= '0;
            left_reg   <= '0;
            sweep_reg  <= '0;
            bidx_reg   <= '0;
            bvalid_reg <= 1'b0;
            dirty_reg  <= 1'b0;
            addr_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            block_reg  <= '0;
            freed_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cur_reg    <= cur_next;
            pos_reg    <= pos_next;
            lim_reg    <= lim_next;
            rsv_reg    <= rsv_next;
            run_reg    <= run_next;
            need_reg   <= need_next;
            want_reg   <= want_next;
            left_reg   <= left_next;
            sweep_reg  <= sweep_next;
            bidx_reg   <= bidx_next;
            bvalid_reg <= bvalid_next;
            dirty_reg  <= dirty_next;
            addr_reg   <= addr_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            block_reg  <= block_next;
            freed_reg  <= freed_next;
        end
    end

    // map memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            buf_reg <= map_mem[mem_raddr];
        end
        else
        begin
            buf_reg <= buf_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign block_address = block_reg;
    assign pages_freed   = freed_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pba_pkg::*;

    localparam int          MAP_PAGES   = POOL_PAGES_DEF;
    localparam int          PAGE_LOG2   = PAGE_BYTES_LOG2_DEF;
    localparam int unsigned PAGE_MASK   = (1 << PAGE_LOG2) - 1;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    // worst request is a full-pool scan plus marking
    localparam int          CYCLE_LIMIT = 20_000_000;
    localparam int          TAIL_CYCLES = 64;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        address;
        logic [COUNT_W-1:0] freed;
    } reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   start;
    logic                   busy;
    logic [1:0]             action;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [31:0]            free_address;
    logic                   done;
    logic [1:0]             status;
    logic [31:0]            block_address;
    logic [COUNT_W-1:0]     pages_freed;

    // predicted use map and register shadows
    logic [MAP_PAGES-1:0]   page_map;
    logic [31:0]            shadow_base;
    logic [COUNT_W-1:0]     shadow_pages;
    logic [COUNT_W-1:0]     shadow_reserved;

    reply_t                 pending_replies[$];
    reply_t                 oldest_reply;
    logic [31:0]            live_blocks[$];
    int                     mismatches;
    int                     cycle_count;
    bit                     idle_enabled;

    page_bitmap_allocator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .request_bytes (request_bytes),
        .free_address  (free_address),
        .done          (done),
        .status        (status),
        .block_address (block_address),
        .pages_freed   (pages_freed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles", $time, cycle_count);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // pages past the parameter size never take part
    function automatic int unsigned live_pages();
        return (shadow_pages < MAP_PAGES) ? int'(shadow_pages) : MAP_PAGES;
    endfunction

    // works out the reply for one request and updates the predicted map
    function automatic reply_t compute_reply(input logic [1:0] act,
                                             input logic [REQ_BYTES_W-1:0] bytes,
                                             input logic [31:0] addr);
        reply_t      r;
        int unsigned lim;
        int unsigned keep;
        int unsigned want;
        int unsigned need;
        int unsigned pos;
        int unsigned run;
        int unsigned pg;
        int unsigned cnt;
        bit          found;
        logic [31:0] offset;
        r = '0;
        lim = live_pages();
        case (act)
            ACT_INIT:
            begin
                // reserve count saturates at the pool size
                keep = (shadow_reserved < lim) ? int'(shadow_reserved) : lim;
                page_map = '0;
                for (int k = 0; k < keep; k++)
                    page_map[k] = 1'b1;
                r.status = ST_OK;
            end
            ACT_ALLOC:
            begin
                if (bytes == '0)
                    r.status = ST_ZERO;
                else
                begin
                    want = (int'(bytes) + PAGE_MASK) >> PAGE_LOG2;
                    if (want == 1)
                        want = MIN_PAGES;
                    // one leading guard page in front of the block
                    need = want + 1;
                    pos = 0;
                    found = 1'b0;
                    r.status = ST_NO_FIT;
                    while (!found && pos + need <= lim)
                    begin
                        run = 0;
                        while (run < need && !page_map[pos + run])
                            run++;
                        if (run == need)
                        begin
                            // the last page of the run stays clear
                            for (int k = 1; k < want; k++)
                                page_map[pos + k] = 1'b1;
                            offset = 32'(pos + 1) << PAGE_LOG2;
                            r.address = shadow_base + offset;
                            r.status = ST_OK;
                            found = 1'b1;
                        end
                        else
                            pos = pos + run + 1;
                    end
                end
            end
            ACT_FREE:
            begin
                // index is taken modulo 2^32, so addresses below the base land far out
                offset = addr - shadow_base;
                pg = offset >> PAGE_LOG2;
                cnt = 0;
                while (pg < lim && page_map[pg])
                begin
                    page_map[pg] = 1'b0;
                    pg++;
                    cnt++;
                end
                r.freed = COUNT_W'(cnt);
                r.status = ST_OK;
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // reply checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t reply with none outstanding: status %0d address %h freed %0d",
                         $time, status, block_address, pages_freed);
                mismatches++;
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (status !== oldest_reply.status)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, oldest_reply.status, status);
                    mismatches++;
                end
                if (block_address !== oldest_reply.address)
                begin
                    $display("%0t block_address mismatch: expected %h actual %h",
                             $time, oldest_reply.address, block_address);
                    mismatches++;
                end
                if (pages_freed !== oldest_reply.freed)
                begin
                    $display("%0t pages_freed mismatch: expected %0d actual %0d",
                             $time, oldest_reply.freed, pages_freed);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    task automatic apb_transfer(input logic [1:0] reg_idx, input bit is_write,
                                input logic [31:0] value, output logic [31:0] read_value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        read_value = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // write one register, update the shadow and read it back
    task automatic set_register(input logic [1:0] reg_idx, input logic [31:0] value);
        logic [31:0] ignored;
        logic [31:0] readback;
        logic [31:0] stored;
        apb_transfer(reg_idx, 1'b1, value, ignored);
        case (reg_idx)
            REG_POOL_BASE:      shadow_base     = value;
            REG_POOL_PAGES:     shadow_pages    = value[COUNT_W-1:0];
            REG_RESERVED_PAGES: shadow_reserved = value[COUNT_W-1:0];
            default:            ;
        endcase
        stored = (reg_idx == REG_POOL_BASE) ? value : 32'(value[COUNT_W-1:0]);
        apb_transfer(reg_idx, 1'b0, '0, readback);
        if (readback !== stored)
        begin
            $display("%0t register %0d readback mismatch: expected %h actual %h",
                     $time, reg_idx, stored, readback);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // start is left high so back-to-back requests stay back to back
    task automatic send_request(input logic [1:0] act, input logic [REQ_BYTES_W-1:0] bytes,
                                input logic [31:0] addr, output reply_t reply);
        @(negedge clk);
        start         = 1'b1;
        action        = act;
        request_bytes = bytes;
        free_address  = addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reply = compute_reply(act, bytes, addr);
        pending_replies.push_back(reply);
    endtask

    task automatic idle_gap();
        int pick;
        int cycles;
        if (!idle_enabled)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cycles = 0;
        else if (pick < 92)
            cycles = $urandom_range(1, 3);
        else
            cycles = $urandom_range(8, 40);
        if (cycles > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // hold requests off until every outstanding reply is back
    task automatic drain_replies();
        @(negedge clk);
        start = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed_requests();
        reply_t      r;
        logic [31:0] blk_min;
        logic [31:0] blk_page;
        blk_min = '0;
        blk_page = '0;
        set_register(REG_POOL_BASE, 32'h4000_0000);
        set_register(REG_POOL_PAGES, 32'd16);
        set_register(REG_RESERVED_PAGES, 32'd3);
        send_request(ACT_INIT, '0, '0, r);
        // zero size, one byte rounds to the two page minimum, page rounding both sides
        send_request(ACT_ALLOC, '0, '0, r);
        send_request(ACT_ALLOC, 18'd1, '0, r);
        blk_min = r.address;
        send_request(ACT_ALLOC, 18'd128, '0, r);
        blk_page = r.address;
        send_request(ACT_ALLOC, 18'd129, '0, r);
        // far too large for any pool
        send_request(ACT_ALLOC, 18'h3FFFF, '0, r);
        send_request(ACT_ALLOC, 18'd256, '0, r);
        send_request(ACT_FREE, '0, blk_page, r);
        // below the base wraps to a huge page index
        send_request(ACT_FREE, '0, 32'h4000_0000 - 32'd128, r);
        // reserved pages free like any other
        send_request(ACT_FREE, '0, 32'h4000_0000, r);
        // offset inside the page
        send_request(ACT_FREE, '0, blk_min + 32'd5, r);
        send_request(ACT_UNUSED, 18'h3FFFF, 32'hFFFF_FFFF, r);
        send_request(ACT_ALLOC, 18'd1, '0, r);
        send_request(ACT_INIT, '0, '0, r);
        send_request(ACT_FREE, '0, 32'h4000_0000 + 32'd15 * 32'd128, r);
        drain_replies();
    endtask

    task automatic test_register_extremes();
        reply_t r;
        // empty pool: nothing fits, nothing frees
        set_register(REG_POOL_PAGES, 32'd0);
        send_request(ACT_INIT, '0, '0, r);
        send_request(ACT_ALLOC, 18'd1, '0, r);
        send_request(ACT_FREE, '0, shadow_base, r);
        drain_replies();
        // pool and reserve counts beyond the map saturate; the block address wraps
        set_register(REG_POOL_BASE, 32'hFFFF_FF80);
        set_register(REG_POOL_PAGES, 32'hFFFF_FFFF);
        set_register(REG_RESERVED_PAGES, 32'h0000_07FF);
        send_request(ACT_INIT, '0, '0, r);
        send_request(ACT_ALLOC, 18'd1, '0, r);
        send_request(ACT_FREE, '0, 32'hFFFF_FF80, r);
        send_request(ACT_ALLOC, 18'h3FFFF, '0, r);
        // whole pool as one run, guard page first
        send_request(ACT_ALLOC, 18'(1023 * 128), '0, r);
        send_request(ACT_FREE, '0, r.address, r);
        drain_replies();
        set_register(REG_RESERVED_PAGES, 32'd0);
        set_register(REG_POOL_BASE, 32'hFFFF_FFFF);
        send_request(ACT_INIT, '0, '0, r);
        send_request(ACT_ALLOC, 18'd300, '0, r);
        send_request(ACT_FREE, '0, r.address, r);
        drain_replies();
    endtask

    task automatic pick_alloc_size(output logic [REQ_BYTES_W-1:0] bytes);
        int unsigned cap;
        int          pick;
        cap = live_pages() * 128 / 5;
        if (cap < 1)
            cap = 1;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            bytes = '0;
        else if (pick < 10)
            bytes = REQ_BYTES_W'($urandom);
        else if (pick < 25)
            bytes = REQ_BYTES_W'($urandom_range(1, 20) * 128 + $urandom_range(0, 2) - 1);
        else if (pick < 45)
            bytes = REQ_BYTES_W'($urandom_range(1, 256));
        else
            bytes = REQ_BYTES_W'($urandom_range(1, cap));
    endtask

    task automatic pick_free_address(output logic [31:0] addr);
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (live_blocks.size() != 0 && pick < 75)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            addr = live_blocks[idx];
            live_blocks.delete(idx);
            if ($urandom_range(0, 7) == 0)
                addr = addr + $urandom_range(1, 127);
        end
        else if (live_pages() != 0 && pick < 90)
            addr = shadow_base + (32'($urandom_range(0, live_pages() - 1)) << PAGE_LOG2)
                   + $urandom_range(0, 127);
        else
            addr = $urandom;
    endtask

    // one traffic phase over a given pool geometry
    task automatic test_random_traffic(input int n_items, input logic [31:0] base,
                                       input logic [31:0] pages, input logic [31:0] reserved,
                                       input bit with_idle);
        reply_t                 r;
        logic [REQ_BYTES_W-1:0] bytes;
        logic [31:0]            addr;
        int                     pick;
        set_register(REG_POOL_BASE, base);
        set_register(REG_POOL_PAGES, pages);
        set_register(REG_RESERVED_PAGES, reserved);
        idle_enabled = with_idle;
        live_blocks.delete();
        send_request(ACT_INIT, REQ_BYTES_W'($urandom), $urandom, r);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                send_request(ACT_INIT, REQ_BYTES_W'($urandom), $urandom, r);
                live_blocks.delete();
            end
            else if (pick < 55)
            begin
                pick_alloc_size(bytes);
                send_request(ACT_ALLOC, bytes, $urandom, r);
                if (r.status == ST_OK)
                    live_blocks.push_back(r.address);
            end
            else if (pick < 94)
            begin
                pick_free_address(addr);
                send_request(ACT_FREE, REQ_BYTES_W'($urandom), addr, r);
            end
            else
                send_request(ACT_UNUSED, REQ_BYTES_W'($urandom), $urandom, r);
            // sender holds off until everything is back, mid-phase and now and then
            if (i == n_items / 2 || $urandom_range(0, 99) == 0)
                drain_replies();
            idle_gap();
        end
        drain_replies();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        action          = ACT_INIT;
        request_bytes   = '0;
        free_address    = '0;
        mismatches      = 0;
        idle_enabled    = 1'b0;
        page_map        = '0;
        shadow_base     = '0;
        shadow_pages    = POOL_PAGES_RST;
        shadow_reserved = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_requests();
        test_register_extremes();
        // most phases keep the pool small so scans stay short
        test_random_traffic(200, 32'h0000_0000, 32'd24, 32'd0, 1'b1);
        test_random_traffic(200, $urandom & ~32'h7F, 32'd64, 32'd5, 1'b1);
        test_random_traffic(200, $urandom & ~32'h7F, 32'd128, 32'd2, 1'b1);
        test_random_traffic(180, $urandom & ~32'h7F, 32'd40, 32'd50, 1'b1);
        test_random_traffic(150, $urandom & ~32'h7F, 32'd2047, 32'd7, 1'b1);
        test_random_traffic(200, $urandom, 32'd8, 32'd1, 1'b1);
        test_random_traffic(200, 32'hFFFF_F000, 32'd200, 32'd0, 1'b1);
        // back-to-back stretch with no sender gaps
        test_random_traffic(240, $urandom & ~32'h7F, 32'd100, 32'd3, 1'b0);

        drain_replies();
        // catch any stray reply after the last expected one
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
